FILE: rtl/icrs_pkg.sv
// ----------------------------------------------------------------------------
// icrs_pkg
// Shared types and constants of the inverse-CDF rank sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package icrs_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int IDX_W       = 10;
    localparam int VAL_W       = 32;
    localparam int Z_W         = 33;
    localparam int CFG_W       = 11;
    localparam int RANK_W      = 11;
    localparam int N_W         = (CFG_W > ADDR_W + 1) ? CFG_W : ADDR_W + 1;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic {
        K_LOAD  = 1'b0,
        K_QUERY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
        logic [Z_W-1:0]    z;
        logic [ADDR_W-1:0] last;
    } t_cmd;

endpackage

`default_nettype wire

FILE: rtl/icrs_front.sv
// ----------------------------------------------------------------------------
// icrs_front
// Holds the entry count, classifies input beats and packs them as commands.
// ----------------------------------------------------------------------------
`default_nettype none

module icrs_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [icrs_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire                           i_valid,
    input  wire                           i_action,
    input  wire [icrs_pkg::IDX_W-1:0]     i_entry_index,
    input  wire [icrs_pkg::VAL_W-1:0]     i_entry_value,
    input  wire [icrs_pkg::Z_W-1:0]       i_uniform_value,
    input  wire                           i_q_full,
    output logic                          o_ready,
    output logic                          o_push,
    output icrs_pkg::t_cmd                o_cmd
);

    logic [icrs_pkg::CFG_W-1:0] r_entries_in_use;
    logic [icrs_pkg::N_W-1:0]   cnt_ext;
    logic [icrs_pkg::N_W-1:0]   n_clamped;
    logic [icrs_pkg::N_W-1:0]   last_ext;
    logic [icrs_pkg::N_W-1:0]   idx_ext;
    logic                       keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= icrs_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            r_entries_in_use <= i_cfg_data;
        end
    end

    always_comb begin
        cnt_ext = icrs_pkg::N_W'(r_entries_in_use);
        if (cnt_ext == '0) begin
            n_clamped = icrs_pkg::N_W'(1);
        end else if (cnt_ext > icrs_pkg::N_W'(icrs_pkg::MAX_ENTRIES)) begin
            n_clamped = icrs_pkg::N_W'(icrs_pkg::MAX_ENTRIES);
        end else begin
            n_clamped = cnt_ext;
        end
        last_ext = n_clamped - icrs_pkg::N_W'(1);
        idx_ext  = icrs_pkg::N_W'(i_entry_index);
        keep     = i_action || (idx_ext < icrs_pkg::N_W'(icrs_pkg::MAX_ENTRIES));
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready && keep;

    always_comb begin
        o_cmd.kind = i_action ? icrs_pkg::K_QUERY : icrs_pkg::K_LOAD;
        o_cmd.addr = idx_ext[icrs_pkg::ADDR_W-1:0];
        o_cmd.data = i_entry_value;
        o_cmd.z    = i_uniform_value;
        o_cmd.last = last_ext[icrs_pkg::ADDR_W-1:0];
    end

endmodule

`default_nettype wire

FILE: rtl/icrs_queue.sv
// ----------------------------------------------------------------------------
// icrs_queue
// Short command queue between the front and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module icrs_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  icrs_pkg::t_cmd i_cmd,
    input  wire            i_pop,
    output logic           o_full,
    output logic           o_valid,
    output icrs_pkg::t_cmd o_cmd
);

    icrs_pkg::t_cmd              r_slot [icrs_pkg::QDEPTH];
    logic [icrs_pkg::QPTR_W-1:0] r_wptr;
    logic [icrs_pkg::QPTR_W-1:0] r_rptr;
    logic [icrs_pkg::QCNT_W-1:0] r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == icrs_pkg::QCNT_W'(icrs_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == icrs_pkg::QPTR_W'(icrs_pkg::QDEPTH - 1))
                          ? '0 : r_wptr + icrs_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == icrs_pkg::QPTR_W'(icrs_pkg::QDEPTH - 1))
                          ? '0 : r_rptr + icrs_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + icrs_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - icrs_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/icrs_back.sv
// ----------------------------------------------------------------------------
// icrs_back
// Table memory and binary search engine, one probe per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module icrs_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_q_valid,
    input  icrs_pkg::t_cmd                 i_q_cmd,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [icrs_pkg::RANK_W-1:0]    o_rank
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_LAST = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic [icrs_pkg::VAL_W-1:0]  r_table [icrs_pkg::MAX_ENTRIES];
    logic [icrs_pkg::VAL_W-1:0]  r_rdata;
    logic [icrs_pkg::ADDR_W-1:0] r_lo;
    logic [icrs_pkg::ADDR_W-1:0] n_lo;
    logic [icrs_pkg::ADDR_W-1:0] r_hi;
    logic [icrs_pkg::ADDR_W-1:0] n_hi;
    logic [icrs_pkg::ADDR_W-1:0] r_mid;
    logic [icrs_pkg::ADDR_W-1:0] n_mid;
    logic [icrs_pkg::Z_W-1:0]    r_z;
    logic [icrs_pkg::Z_W-1:0]    n_z;
    logic [icrs_pkg::RANK_W-1:0] r_rank;
    logic [icrs_pkg::RANK_W-1:0] n_rank;
    logic [icrs_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic                        le_z;
    logic                        decide;
    logic [icrs_pkg::ADDR_W-1:0] cand_lo;
    logic [icrs_pkg::ADDR_W-1:0] cand_hi;
    logic [icrs_pkg::ADDR_W-1:0] span;
    logic [icrs_pkg::ADDR_W:0]   mid_sum;
    logic [icrs_pkg::N_W-1:0]    rank_ext;

    assign le_z     = ({1'b0, r_rdata} <= r_z);
    assign o_valid  = (r_state == S_DONE);
    assign o_rank   = r_rank;

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_z      = r_z;
        n_rank   = r_rank;
        o_q_pop  = 1'b0;
        wr_en    = 1'b0;
        decide   = 1'b0;
        cand_lo  = r_lo;
        cand_hi  = r_hi;
        rd_addr  = r_mid;
        span     = '0;
        mid_sum  = '0;
        rank_ext = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.kind == icrs_pkg::K_LOAD) begin
                        wr_en = 1'b1;
                    end else begin
                        n_z     = i_q_cmd.z;
                        cand_lo = '0;
                        cand_hi = i_q_cmd.last;
                        decide  = 1'b1;
                    end
                end
            end
            S_STEP: begin
                if (le_z) begin
                    cand_lo = r_mid;
                end else begin
                    cand_hi = r_mid;
                end
                decide = 1'b1;
            end
            S_LAST: begin
                n_lo     = le_z ? r_hi : r_lo;
                rank_ext = icrs_pkg::N_W'(n_lo) + icrs_pkg::N_W'(1);
                n_rank   = rank_ext[icrs_pkg::RANK_W-1:0];
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (decide) begin
            n_lo     = cand_lo;
            n_hi     = cand_hi;
            span     = cand_hi - cand_lo;
            mid_sum  = {1'b0, cand_lo} + {1'b0, cand_hi};
            rank_ext = icrs_pkg::N_W'(cand_lo) + icrs_pkg::N_W'(1);
            if (span >= icrs_pkg::ADDR_W'(2)) begin
                n_mid   = mid_sum[icrs_pkg::ADDR_W:1];
                rd_addr = n_mid;
                n_state = S_STEP;
            end else if (cand_lo < cand_hi) begin
                rd_addr = cand_hi;
                n_state = S_LAST;
            end else begin
                n_rank  = rank_ext[icrs_pkg::RANK_W-1:0];
                n_state = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[i_q_cmd.addr] <= i_q_cmd.data;
        end
        r_rdata <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_z    <= n_z;
        r_rank <= n_rank;
    end

endmodule

`default_nettype wire

FILE: rtl/inverse_cdf_rank_sampler_top.sv
// ----------------------------------------------------------------------------
// inverse_cdf_rank_sampler_top
// Inverse-CDF rank sampler: table loads and binary-search rank queries.
// ----------------------------------------------------------------------------
// Search: one table probe per cycle in the search engine; the engine takes no
//   new command while a query is in flight or while its result waits.
// The front keeps taking beats into a two-entry queue while a result waits.
// Reset: synchronous, active low; clears queue and engine state, sets the
//   entry count to 1. Table contents are undefined until loaded.
`default_nettype none

module inverse_cdf_rank_sampler_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [icrs_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                            i_valid,
    output logic                           o_ready,
    input  wire                            i_action,
    input  wire [icrs_pkg::IDX_W-1:0]      i_entry_index,
    input  wire [icrs_pkg::VAL_W-1:0]      i_entry_value,
    input  wire [icrs_pkg::Z_W-1:0]        i_uniform_value,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic [icrs_pkg::RANK_W-1:0]    o_rank
);

    icrs_pkg::t_cmd front_cmd;
    icrs_pkg::t_cmd q_cmd;
    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    icrs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_uniform_value (i_uniform_value),
        .i_q_full        (q_full),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_cmd           (front_cmd)
    );

    icrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    icrs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_rank    (o_rank)
    );

endmodule

`default_nettype wire

FILE: rtl/icrs_checker.sv
// ----------------------------------------------------------------------------
// icrs_checker
// Port-level checks of the rank sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module icrs_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            o_ready,
    input  wire                            o_valid,
    input  wire                            i_ready,
    input  wire [icrs_pkg::RANK_W-1:0]     o_rank
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rank))
        else $error("result beat dropped or changed while stalled");

    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rank != '0) && (32'(o_rank) <= 32'(icrs_pkg::MAX_ENTRIES)))
        else $error("rank out of range");

    a_gap_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result beat repeated");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("bad state after reset");

endmodule

bind inverse_cdf_rank_sampler_top icrs_checker u_chk (.*);

`default_nettype wire
